// File: hdl/kvls_pkg.sv
// Package for the key/value line splitter: status codes, character codes
// and the result record. No dependencies.
`default_nettype none
package kvls_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_EQUALS    = 3'd1,
    STATUS_NO_KEY    = 3'd2,
    STATUS_NO_VALUE  = 3'd3,
    STATUS_TOO_LONG  = 3'd4
  } status_t;

  // Character codes
  localparam logic [7:0] CHAR_EQUALS = 8'h3D;
  localparam logic [7:0] CHAR_HASH   = 8'h23;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;

  // One parsed line
  typedef struct packed {
    status_t    status;
    logic [7:0] key_start;
    logic [7:0] key_length;
    logic [7:0] value_start;
    logic [7:0] value_length;
  } result_t;

endpackage
`default_nettype wire

// File: hdl/kvls_stream_if.sv
// Valid/ready channel interfaces for the key/value line splitter:
// the character stream and the result stream. No dependencies.
`default_nettype none
interface kvls_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       line_end;

  modport source (output valid, output character, output line_end, input ready);
  modport sink   (input valid, input character, input line_end, output ready);
endinterface

interface kvls_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] key_start;
  logic [7:0] key_length;
  logic [7:0] value_start;
  logic [7:0] value_length;

  modport source (output valid, output status, output key_start, output key_length,
                  output value_start, output value_length, input ready);
  modport sink   (input valid, input status, input key_start, input key_length,
                  input value_start, input value_length, output ready);
endinterface
`default_nettype wire

// File: hdl/key_value_line_splitter_core.sv
// Key/value line splitter: scans a text line one character per transfer and
// reports status, key and value extents at the line end.
// The line result is registered into the buffer head, or into the skid while the head
// stalls. Throughput: one character per cycle while the skid is empty; a two-entry
// result buffer (head plus skid) lets characters flow while a result waits to be taken.
// Reset (rst, synchronous): clears the line scan state and empties the buffer.
// Depends on kvls_pkg and the interfaces in kvls_stream_if.sv.
`default_nettype none
module key_value_line_splitter_core #(
  parameter int LINE_MAX = 256
) (
  input  wire            clk,
  input  wire            rst,
  kvls_char_if.sink      chars,
  kvls_result_if.source  results
);
  import kvls_pkg::*;

  localparam logic [8:0] POS_LIMIT = (LINE_MAX < 256) ? 9'(LINE_MAX) : 9'd256;

  // Line scan state
  logic [8:0] position;
  logic       seen_nonspace;
  logic       lead_is_bad;
  logic [7:0] key_first;
  logic [7:0] key_last;
  logic [1:0] equals_count;
  logic       value_seen;
  logic [7:0] value_first;
  logic [7:0] value_last;

  logic [8:0] position_next;
  logic       seen_nonspace_next;
  logic       lead_is_bad_next;
  logic [7:0] key_first_next;
  logic [7:0] key_last_next;
  logic [1:0] equals_count_next;
  logic       value_seen_next;
  logic [7:0] value_first_next;
  logic [7:0] value_last_next;

  // Result buffer: head drives the port, skid catches a result while head stalls
  result_t head;
  result_t skid;
  logic    head_valid;
  logic    skid_valid;
  result_t line_result;

  logic [7:0] c;
  logic [7:0] pos;
  logic       c_blank;
  logic       c_white;
  logic       c_equals;
  logic       accept;
  logic       produce;
  logic       pop;

  assign c        = chars.character;
  assign pos      = position[7:0];
  assign c_blank  = (c == CHAR_SPACE) || (c == CHAR_TAB);
  assign c_white  = c_blank || (c == CHAR_CR) || (c == CHAR_LF);
  assign c_equals = (c == CHAR_EQUALS);

  assign chars.ready = !skid_valid;
  assign accept      = chars.valid && chars.ready;
  assign produce     = accept && chars.line_end;
  assign pop         = head_valid && results.ready;

  // Advance the scan state by one character
  always_comb begin
    seen_nonspace_next = seen_nonspace;
    lead_is_bad_next   = lead_is_bad;
    key_first_next     = key_first;
    key_last_next      = key_last;
    value_seen_next    = value_seen;
    value_first_next   = value_first;
    value_last_next    = value_last;
    if (equals_count == 2'd0) begin
      if (!c_blank) begin
        if (!seen_nonspace) begin
          seen_nonspace_next = 1'b1;
          lead_is_bad_next   = (c == CHAR_HASH) || c_equals;
          key_first_next     = pos;
        end
        if (!c_equals) begin
          key_last_next = pos;
        end
      end
    end else if (!c_equals && !c_white) begin
      if (!value_seen) begin
        value_seen_next  = 1'b1;
        value_first_next = pos;
      end
      value_last_next = pos;
    end
    equals_count_next = equals_count;
    if (c_equals && (equals_count != 2'd2)) begin
      equals_count_next = equals_count + 2'd1;
    end
    position_next = position;
    if (position <= POS_LIMIT) begin
      position_next = position + 9'd1;
    end
  end

  // Classify the line from the updated state
  always_comb begin
    line_result = '0;
    if (position_next > POS_LIMIT) begin
      line_result.status = STATUS_TOO_LONG;
    end else if (equals_count_next != 2'd1) begin
      line_result.status = STATUS_EQUALS;
    end else if (!seen_nonspace_next || lead_is_bad_next) begin
      line_result.status = STATUS_NO_KEY;
    end else if (!value_seen_next) begin
      line_result.status = STATUS_NO_VALUE;
    end else begin
      line_result.status       = STATUS_OK;
      line_result.key_start    = key_first_next;
      line_result.key_length   = key_last_next - key_first_next + 8'd1;
      line_result.value_start  = value_first_next;
      line_result.value_length = value_last_next - value_first_next + 8'd1;
    end
  end

  // Hold the scan state; clear it after each line end
  always_ff @(posedge clk) begin
    if (rst || produce) begin
      position      <= '0;
      seen_nonspace <= 1'b0;
      lead_is_bad   <= 1'b0;
      key_first     <= '0;
      key_last      <= '0;
      equals_count  <= '0;
      value_seen    <= 1'b0;
      value_first   <= '0;
      value_last    <= '0;
    end else if (accept) begin
      position      <= position_next;
      seen_nonspace <= seen_nonspace_next;
      lead_is_bad   <= lead_is_bad_next;
      key_first     <= key_first_next;
      key_last      <= key_last_next;
      equals_count  <= equals_count_next;
      value_seen    <= value_seen_next;
      value_first   <= value_first_next;
      value_last    <= value_last_next;
    end
  end

  // Move results through head and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        head_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        head_valid <= produce;
      end
    end else if (produce) begin
      if (head_valid) begin
        skid_valid <= 1'b1;
      end else begin
        head_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        head <= skid;
      end else if (produce) begin
        head <= line_result;
      end
    end else if (produce) begin
      if (head_valid) begin
        skid <= line_result;
      end else begin
        head <= line_result;
      end
    end
  end

  assign results.valid        = head_valid;
  assign results.status       = head.status;
  assign results.key_start    = head.key_start;
  assign results.key_length   = head.key_length;
  assign results.value_start  = head.value_start;
  assign results.value_length = head.value_length;

endmodule
`default_nettype wire

// File: hdl/kvls_checker.sv
// Port-level checks for the key/value line splitter result stream, and the
// bind that attaches them to key_value_line_splitter_core. Uses kvls_pkg.
`default_nettype none
module kvls_checker (
  input wire       clk,
  input wire       rst,
  input wire       result_valid,
  input wire       result_ready,
  input wire [2:0] status,
  input wire [7:0] key_start,
  input wire [7:0] key_length,
  input wire [7:0] value_start,
  input wire [7:0] value_length
);
  import kvls_pkg::*;

  // A stalled result stays and holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(status)
      && $stable(key_start) && $stable(key_length) && $stable(value_start)
      && $stable(value_length))
    else $error("result changed while stalled");

  // Reset leaves no result pending
  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // A failed line carries zero extents
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status != STATUS_OK) |-> key_start == 8'd0 && key_length == 8'd0
      && value_start == 8'd0 && value_length == 8'd0)
    else $error("failed line with nonzero extents");

  // A good line has a nonempty key before a nonempty value
  a_ok_shape: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == STATUS_OK) |-> key_length != 8'd0 && value_length != 8'd0
      && value_start > key_start)
    else $error("good line with bad key or value extents");

  // Status stays within the defined codes
  a_status: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> status <= STATUS_TOO_LONG)
    else $error("undefined status code");

endmodule

bind key_value_line_splitter_core kvls_checker u_kvls_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (results.valid),
  .result_ready (results.ready),
  .status       (results.status),
  .key_start    (results.key_start),
  .key_length   (results.key_length),
  .value_start  (results.value_start),
  .value_length (results.value_length)
);
`default_nettype wire

// File: sim/tb_key_value_line_splitter_core.sv
// Testbench for key_value_line_splitter_core: drives text lines one character
// per transfer and checks each line result against a built-in line scanner.
// Depends on kvls_pkg, kvls_stream_if.sv and the core itself.
`default_nettype none
module tb_key_value_line_splitter_core;
  import kvls_pkg::*;

  localparam int LINE_MAX      = 256;
  localparam int POS_LIMIT     = (LINE_MAX < 256) ? LINE_MAX : 256;
  localparam int RANDOM_CHARS  = 300;
  localparam int WATCHDOG_MAX  = 2000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int REPORT_MAX    = 10;

  logic clk;
  logic rst;

  kvls_char_if   chars_if();
  kvls_result_if results_if();

  key_value_line_splitter_core #(
    .LINE_MAX(LINE_MAX)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_if),
    .results(results_if)
  );

  // Scanner state for the line in progress
  logic [8:0] line_pos;
  logic       seen_nonspace;
  logic       lead_bad;
  logic [7:0] key_first;
  logic [7:0] key_last;
  logic [1:0] eq_count;
  logic       val_seen;
  logic [7:0] val_first;
  logic [7:0] val_last;

  result_t    expected_splits[$];
  logic [7:0] line_buf[$];

  int chars_sent;
  int lines_sent;
  int results_checked = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int status_seen[5] = '{default: 0};
  bit src_idle_en;
  bit snk_idle_en;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic clear_line_state();
    line_pos      = '0;
    seen_nonspace = 1'b0;
    lead_bad      = 1'b0;
    key_first     = '0;
    key_last      = '0;
    eq_count      = '0;
    val_seen      = 1'b0;
    val_first     = '0;
    val_last      = '0;
  endtask

  // Advance the scanner by one character; queue a result at the line end
  task automatic scan_character(input logic [7:0] c, input logic last);
    logic [7:0] pos;
    logic       blank;
    logic       white;
    result_t    r;
    pos   = line_pos[7:0];
    blank = (c == CHAR_SPACE) || (c == CHAR_TAB);
    white = blank || (c == CHAR_CR) || (c == CHAR_LF);
    if (eq_count == 0) begin
      if (!blank) begin
        if (!seen_nonspace) begin
          seen_nonspace = 1'b1;
          lead_bad      = (c == CHAR_HASH) || (c == CHAR_EQUALS);
          key_first     = pos;
        end
        if (c != CHAR_EQUALS) key_last = pos;
      end
    end else if (c != CHAR_EQUALS && !white) begin
      if (!val_seen) begin
        val_seen  = 1'b1;
        val_first = pos;
      end
      val_last = pos;
    end
    if (c == CHAR_EQUALS && eq_count < 2) eq_count = eq_count + 2'd1;
    if (line_pos <= POS_LIMIT) line_pos = line_pos + 9'd1;
    if (last) begin
      r = '0;
      if (line_pos > POS_LIMIT) begin
        r.status = STATUS_TOO_LONG;
      end else if (eq_count != 1) begin
        r.status = STATUS_EQUALS;
      end else if (!seen_nonspace || lead_bad) begin
        r.status = STATUS_NO_KEY;
      end else if (!val_seen) begin
        r.status = STATUS_NO_VALUE;
      end else begin
        r.status       = STATUS_OK;
        r.key_start    = key_first;
        r.key_length   = key_last - key_first + 8'd1;
        r.value_start  = val_first;
        r.value_length = val_last - val_first + 8'd1;
      end
      expected_splits.push_back(r);
      clear_line_state();
    end
  endtask

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Drive one character and hold it until the transfer; starts and ends at negedge
  task automatic send_character(input logic [7:0] c, input logic last);
    int gap;
    gap = src_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      chars_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    chars_if.valid     <= 1'b1;
    chars_if.character <= c;
    chars_if.line_end  <= last;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    scan_character(c, last);
    chars_sent++;
    @(negedge clk);
  endtask

  // Send the buffered line, marking its last character, and empty the buffer
  task automatic send_line();
    int n;
    n = line_buf.size();
    for (int i = 0; i < n; i++) send_character(line_buf[i], i == n - 1);
    line_buf.delete();
    lines_sent++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic add_repeat(input logic [7:0] c, input int n);
    for (int i = 0; i < n; i++) line_buf.push_back(c);
  endtask

  function automatic logic [7:0] blank_char();
    return ($urandom_range(0, 1) == 0) ? CHAR_SPACE : CHAR_TAB;
  endfunction

  function automatic logic [7:0] white_char();
    case ($urandom_range(0, 3))
      0: return CHAR_SPACE;
      1: return CHAR_TAB;
      2: return CHAR_CR;
      default: return CHAR_LF;
    endcase
  endfunction

  function automatic logic [7:0] key_char();
    case ($urandom_range(0, 4))
      0, 1: return 8'h61 + 8'($urandom_range(0, 25));
      2: return 8'h41 + 8'($urandom_range(0, 25));
      3: return 8'h30 + 8'($urandom_range(0, 9));
      default: return ($urandom_range(0, 1) == 0) ? 8'h5F : 8'h2E;
    endcase
  endfunction

  function automatic logic [7:0] value_char();
    logic [7:0] c;
    if ($urandom_range(0, 9) == 0) return 8'h80 + 8'($urandom_range(0, 127));
    c = 8'h21 + 8'($urandom_range(0, 93));
    return (c == CHAR_EQUALS) ? 8'h3A : c;
  endfunction

  task automatic add_blanks(input int n);
    for (int i = 0; i < n; i++) line_buf.push_back(blank_char());
  endtask

  task automatic add_whites(input int n);
    for (int i = 0; i < n; i++) line_buf.push_back(white_char());
  endtask

  // Key or value text, with an occasional inner blank
  task automatic add_word(input int n, input bit is_key);
    for (int i = 0; i < n; i++) begin
      if (i > 0 && i < n - 1 && $urandom_range(0, 7) == 0) line_buf.push_back(blank_char());
      else line_buf.push_back(is_key ? key_char() : value_char());
    end
  endtask

  task automatic test_directed_lines();
    add_text("key=value");                          send_line();
    add_text(" \tname \t=\t some value \t\r\n");    send_line();
    add_text("k=v");                                send_line();
    add_text("no equals here");                     send_line();
    add_text("a==b");                               send_line();
    add_text("a=b=");                               send_line();
    add_text("# note");                             send_line();
    add_text("#key=value");                         send_line();
    add_text(" =value");                            send_line();
    add_text("=");                                  send_line();
    add_text("   ");                                send_line();
    add_text("key=");                               send_line();
    add_text("key = \t\r\n");                       send_line();
    add_text("\n");                                 send_line();
    add_text("x");                                  send_line();
    // extreme byte values as key and value
    line_buf.push_back(8'h00);
    line_buf.push_back(CHAR_EQUALS);
    line_buf.push_back(8'hFF);
    send_line();
  endtask

  task automatic test_line_length();
    // full-length line, longest value
    add_text("k=");
    add_repeat(8'h76, POS_LIMIT - 2);
    send_line();
    // run on past the limit before the line end so the position saturates
    add_text("key=");
    add_repeat(8'h77, POS_LIMIT);
    send_line();
    // state must be clean afterwards
    add_text("a=b");
    send_line();
  endtask

  task automatic test_random_lines();
    int stop_at;
    stop_at = chars_sent + RANDOM_CHARS;
    while (chars_sent < stop_at) begin
      src_idle_en = ($urandom_range(0, 4) != 0);
      snk_idle_en = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 39) == 0) begin
        // near the length limit
        add_word($urandom_range(1, 4), 1'b1);
        line_buf.push_back(CHAR_EQUALS);
        add_word($urandom_range(POS_LIMIT - 12, POS_LIMIT + 4), 1'b0);
      end else if ($urandom_range(0, 9) < 7) begin
        // well-formed line with random content
        add_blanks($urandom_range(0, 3));
        add_word($urandom_range(1, 8), 1'b1);
        add_blanks($urandom_range(0, 2));
        line_buf.push_back(CHAR_EQUALS);
        add_blanks($urandom_range(0, 2));
        add_word($urandom_range(1, 10), 1'b0);
        add_whites($urandom_range(0, 3));
      end else begin
        case ($urandom_range(0, 6))
          0: begin
            // raw bytes with scattered equals signs
            repeat ($urandom_range(1, 24)) begin
              if ($urandom_range(0, 5) == 0) line_buf.push_back(CHAR_EQUALS);
              else line_buf.push_back(8'($urandom_range(0, 255)));
            end
          end
          1: begin
            add_blanks($urandom_range(0, 2));
            line_buf.push_back(CHAR_HASH);
            add_word($urandom_range(0, 6), 1'b1);
            if ($urandom_range(0, 1) == 0) begin
              line_buf.push_back(CHAR_EQUALS);
              add_word($urandom_range(0, 4), 1'b0);
            end
          end
          2: begin
            add_word($urandom_range(1, 6), 1'b1);
            line_buf.push_back(CHAR_EQUALS);
            add_whites($urandom_range(0, 4));
          end
          3: begin
            add_word($urandom_range(1, 6), 1'b1);
            line_buf.push_back(CHAR_EQUALS);
            add_word($urandom_range(0, 4), 1'b0);
            line_buf.push_back(CHAR_EQUALS);
            add_word($urandom_range(0, 4), 1'b0);
          end
          4: begin
            add_blanks($urandom_range(0, 3));
            line_buf.push_back(CHAR_EQUALS);
            add_word($urandom_range(0, 5), 1'b0);
          end
          5: begin
            add_blanks($urandom_range(0, 3));
            add_word($urandom_range(1, 8), 1'b1);
            add_blanks($urandom_range(0, 3));
          end
          default: add_whites($urandom_range(1, 6));
        endcase
      end
      send_line();
    end
  endtask

  // Result sink: hold ready low for random stretches
  initial begin
    int hold;
    hold = 0;
    results_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        results_if.ready <= 1'b0;
        hold--;
      end else begin
        results_if.ready <= 1'b1;
        if (snk_idle_en && $urandom_range(0, 2) == 0) hold = pick_gap();
      end
    end
  end

  // Compare each result transfer with the oldest expected line result
  always @(posedge clk) begin
    result_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      if (expected_splits.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("ERROR: result with no line pending: status %0d", results_if.status);
        mismatches++;
      end else begin
        want = expected_splits.pop_front();
        results_checked++;
        status_seen[want.status]++;
        if (results_if.status       !== want.status      ||
            results_if.key_start    !== want.key_start   ||
            results_if.key_length   !== want.key_length  ||
            results_if.value_start  !== want.value_start ||
            results_if.value_length !== want.value_length) begin
          if (mismatches < REPORT_MAX)
            $display({"ERROR: result %0d: expected status %0d key %0d/%0d value %0d/%0d, ",
                      "got status %0d key %0d/%0d value %0d/%0d"},
                     results_checked, want.status, want.key_start, want.key_length,
                     want.value_start, want.value_length, results_if.status,
                     results_if.key_start, results_if.key_length,
                     results_if.value_start, results_if.value_length);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run if no transfer happens for too long
  always @(posedge clk) begin
    if ((chars_if.valid && chars_if.ready) || (results_if.valid && results_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_MAX) begin
      $display("ERROR: no transfer for %0d cycles, %0d results pending",
               idle_cycles, expected_splits.size());
      $display("tb_key_value_line_splitter_core failed");
      $finish;
    end
  end

  initial begin
    rst                = 1'b1;
    chars_if.valid     = 1'b0;
    chars_if.character = '0;
    chars_if.line_end  = 1'b0;
    src_idle_en        = 1'b1;
    snk_idle_en        = 1'b1;
    chars_sent         = 0;
    lines_sent         = 0;
    clear_line_state();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_lines();
    test_line_length();
    test_random_lines();

    // Drop valid and drain the outstanding results
    chars_if.valid <= 1'b0;
    while (expected_splits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d lines in %0d characters; checked %0d results, %0d mismatches.",
             lines_sent, chars_sent, results_checked, mismatches);
    $display("Status mix: ok %0d, equals %0d, no key %0d, no value %0d, too long %0d.",
             status_seen[STATUS_OK], status_seen[STATUS_EQUALS], status_seen[STATUS_NO_KEY],
             status_seen[STATUS_NO_VALUE], status_seen[STATUS_TOO_LONG]);
    if (mismatches == 0) begin
      $display("tb_key_value_line_splitter_core passed");
    end else begin
      $display("tb_key_value_line_splitter_core failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
hdl/kvls_pkg.sv
hdl/kvls_stream_if.sv
hdl/key_value_line_splitter_core.sv
hdl/kvls_checker.sv
sim/tb_key_value_line_splitter_core.sv
